### rtl/core/neural_activation_unit_core_assert.svh
// assertion macros for the activation unit checker
`ifndef NEURAL_ACTIVATION_UNIT_CORE_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define NAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("activation unit check failed");

// next-cycle implication
`define NAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("activation unit check failed");

`endif

### rtl/core/nau_pkg.sv
// shared types, constants and exp table for the activation unit
`default_nettype none
package nau_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int ROM_AW          = IDX_W + 1;
  localparam int W_BITS          = FRAC_BITS - IDX_W;
  localparam int EXP_BIAS        = 30 - FRAC_BITS;
  localparam int QUO_W           = 31;
  localparam int SM_SHIFT        = QUO_W - FRAC_BITS;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;

  localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

  localparam logic [2:0] KIND_IDENTITY = 3'd0;
  localparam logic [2:0] KIND_LOGISTIC = 3'd1;
  localparam logic [2:0] KIND_TANH     = 3'd2;
  localparam logic [2:0] KIND_RELU     = 3'd3;
  localparam logic [2:0] KIND_SOFTMAX  = 3'd4;

  localparam logic CMD_DERIV        = 1'b1;
  localparam logic CFG_IDX_ACT_KIND = 1'b0;

  typedef struct packed {
    logic [2:0]          kind;
    logic                deriv;
    logic signed [31:0]  x;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] rem;
    logic [30:0] low;
    logic [30:0] quo;
    logic [31:0] dvs;
    logic        ovf;
    logic        cap;
    logic        dz;
  } div_t;

  typedef logic [31:0] rom_t [0:EXP_TABLE_DEPTH];

  // 2^(i/depth) in q2.30, series sum rounded to nearest
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      z    = 64'(i) * LN2_Q32 / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << 32;
      sum  = term;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * z) >> 32) / 64'(k);
        sum  = sum + term;
      end
      r[i] = 32'((sum + 64'd2) >> 2);
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

endpackage
`default_nettype wire

### rtl/core/nau_exp.sv
// exp front end: range reduction, table interpolation, divider setup
`default_nettype none
module nau_exp import nau_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire side_t       in_side,
  input  wire logic [31:0] in_total,
  output logic             up_ld,
  input  wire logic        dn_ld,
  output logic             out_valid,
  output div_t             out_div
);

  typedef struct packed {
    side_t       side;
    logic [31:0] total;
  } ctx_t;

  logic [7:1] v_r;
  logic [7:1] ld;

  always_comb begin
    ld[7] = !v_r[7] || dn_ld;
    for (int i = 6; i >= 1; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign up_ld = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) v_r[1] <= in_valid;
      for (int i = 2; i <= 7; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 1: exp argument
  ctx_t               s1_ctx_r;
  logic signed [33:0] s1_a_r;
  logic signed [33:0] a_nxt;
  logic signed [33:0] x34;

  always_comb begin
    x34 = 34'(in_side.x);
    case (in_side.kind)
      KIND_LOGISTIC: a_nxt = -x34;
      KIND_TANH:     a_nxt = -(x34 <<< 1);
      default:       a_nxt = x34;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_ctx_r <= '{side: in_side, total: in_total};
      s1_a_r   <= a_nxt;
    end
  end

  // stage 2: partial products with log2(e)
  ctx_t               s2_ctx_r;
  logic [47:0]        s2_pl_r;
  logic signed [48:0] s2_ph_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_ctx_r <= s1_ctx_r;
      s2_pl_r  <= 48'(s1_a_r[16:0]) * 48'(LOG2E_Q30);
      s2_ph_r  <= $signed(s1_a_r[33:17]) * $signed({1'b0, LOG2E_Q30});
    end
  end

  // stage 3: combine, floor to q.frac
  ctx_t               s3_ctx_r;
  logic signed [35:0] s3_y_r;
  logic signed [65:0] prod;

  assign prod = ($signed(66'(s2_ph_r)) <<< 17) + $signed({18'b0, s2_pl_r});

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_ctx_r <= s2_ctx_r;
      s3_y_r   <= prod[65:30];
    end
  end

  // stage 4: table lookup
  ctx_t               s4_ctx_r;
  logic signed [19:0] s4_n_r;
  logic [31:0]        s4_t0_r;
  logic [31:0]        s4_dt_r;
  logic [W_BITS-1:0]  s4_w_r;
  logic [ROM_AW-1:0]  idx0;
  logic [ROM_AW-1:0]  idx1;

  assign idx0 = {1'b0, s3_y_r[FRAC_BITS-1:W_BITS]};
  assign idx1 = idx0 + ROM_AW'(1);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_ctx_r <= s3_ctx_r;
      s4_n_r   <= s3_y_r[35:FRAC_BITS];
      s4_t0_r  <= EXP_ROM[idx0];
      s4_dt_r  <= EXP_ROM[idx1] - EXP_ROM[idx0];
      s4_w_r   <= s3_y_r[W_BITS-1:0];
    end
  end

  // stage 5: interpolation
  ctx_t               s5_ctx_r;
  logic signed [19:0] s5_n_r;
  logic [31:0]        s5_mant_r;
  logic [47:0]        ip;

  assign ip = 48'(s4_dt_r) * 48'({s4_w_r, {IDX_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_ctx_r  <= s4_ctx_r;
      s5_n_r    <= s4_n_r;
      s5_mant_r <= s4_t0_r + ip[47:16];
    end
  end

  // stage 6: scale by 2^n
  ctx_t               s6_ctx_r;
  logic [62:0]        s6_e_r;
  logic               s6_cap_r;
  logic signed [20:0] sh;
  logic [20:0]        amt;
  logic [62:0]        e_nxt;
  logic               cap_nxt;

  always_comb begin
    sh      = {s5_n_r[19], s5_n_r} - 21'(EXP_BIAS);
    amt     = 21'(-sh);
    cap_nxt = (sh > 21'sd31);
    if (cap_nxt) begin
      e_nxt = 63'd1 << 62;
    end else if (!sh[20]) begin
      e_nxt = 63'(s5_mant_r) << sh[4:0];
    end else if (amt >= 21'd32) begin
      e_nxt = '0;
    end else begin
      e_nxt = 63'(s5_mant_r >> amt[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_ctx_r <= s5_ctx_r;
      s6_e_r   <= e_nxt;
      s6_cap_r <= cap_nxt;
    end
  end

  // stage 7: divider operands
  div_t        div_nxt;
  logic [63:0] den;
  logic [47:0] sm_rem;

  always_comb begin
    den            = {1'b0, s6_e_r} + 64'(ONE_FX);
    sm_rem         = s6_e_r[62:SM_SHIFT];
    div_nxt.side   = s6_ctx_r.side;
    div_nxt.quo    = '0;
    div_nxt.rem    = '0;
    div_nxt.low    = '0;
    div_nxt.dvs    = 32'd1;
    div_nxt.ovf    = 1'b0;
    div_nxt.cap    = 1'b0;
    div_nxt.dz     = 1'b0;
    case (s6_ctx_r.side.kind)
      KIND_LOGISTIC, KIND_TANH: begin
        if (|den[63:32]) begin
          div_nxt.low = (den == 64'h1_0000_0000) ? 31'd1 : 31'd0;
        end else begin
          div_nxt.dvs = den[31:0];
          div_nxt.rem = 32'd2;
        end
      end
      KIND_SOFTMAX: begin
        div_nxt.dvs = s6_ctx_r.total;
        div_nxt.rem = sm_rem[31:0];
        div_nxt.low = {s6_e_r[SM_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        div_nxt.ovf = (sm_rem >= 48'(s6_ctx_r.total));
        div_nxt.cap = s6_cap_r;
        div_nxt.dz  = (s6_ctx_r.total == 32'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[7]) out_div <= div_nxt;
  end

  assign out_valid = v_r[7];

endmodule
`default_nettype wire

### rtl/core/nau_div_cell.sv
// one restoring divider cell, one quotient bit per stage
`default_nettype none
module nau_div_cell import nau_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire div_t in_div,
  output logic      up_ld,
  input  wire logic dn_ld,
  output logic      out_valid,
  output div_t      out_div
);

  logic        v_r;
  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;
  div_t        div_nxt;

  assign up_ld = !v_r || dn_ld;

  always_comb begin
    r2           = {in_div.rem, in_div.low[30]};
    diff         = r2 - {1'b0, in_div.dvs};
    ge           = (r2 >= {1'b0, in_div.dvs});
    div_nxt      = in_div;
    div_nxt.rem  = ge ? diff[31:0] : r2[31:0];
    div_nxt.low  = {in_div.low[29:0], 1'b0};
    div_nxt.quo  = {in_div.quo[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ld) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) out_div <= div_nxt;
  end

  assign out_valid = v_r;

endmodule
`default_nettype wire

### rtl/core/nau_post.sv
// result stages: function select, derivative product, clamp, output register
`default_nettype none
module nau_post import nau_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire div_t        in_div,
  output logic             up_ld,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             out_sat,
  output logic             out_dz
);

  logic v1_r;
  logic v2_r;
  logic ld1;
  logic ld2;

  assign ld2   = !v2_r || out_ready;
  assign ld1   = !v1_r || ld2;
  assign up_ld = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
    end
  end

  // stage 1: function value and derivative product
  side_t              s1_side_r;
  logic signed [31:0] s1_val_r;
  logic signed [65:0] s1_prod_r;
  logic               s1_sat_r;
  logic               s1_dz_r;

  logic [16:0]        f_l;
  logic signed [18:0] t;
  logic signed [31:0] f_s;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [31:0] val_nxt;
  logic               dz_nxt;
  logic               pos;

  always_comb begin
    f_l     = in_div.quo[16:0];
    t       = $signed({1'b0, f_l, 1'b0}) - 19'(ONE_FX);
    f_s     = in_div.ovf ? MAX_VAL : $signed({1'b0, in_div.quo});
    pos     = (in_div.side.x > 32'sd0);
    dz_nxt  = 1'b0;
    ma      = '0;
    mb      = '0;
    case (in_div.side.kind)
      KIND_IDENTITY: begin
        val_nxt = (in_div.side.deriv == CMD_DERIV) ? ONE_FX : in_div.side.x;
      end
      KIND_LOGISTIC: begin
        val_nxt = 32'(f_l);
        ma      = 33'(f_l);
        mb      = 33'(ONE_FX) - 33'(f_l);
      end
      KIND_TANH: begin
        val_nxt = 32'(t);
        ma      = 33'(t);
        mb      = 33'(t);
      end
      KIND_SOFTMAX: begin
        dz_nxt  = in_div.dz;
        val_nxt = in_div.dz ? MAX_VAL : f_s;
        ma      = 33'(f_s);
        mb      = 33'(ONE_FX) - 33'(f_s);
      end
      default: begin
        if (in_div.side.deriv == CMD_DERIV) begin
          val_nxt = pos ? ONE_FX : 32'sd0;
        end else begin
          val_nxt = pos ? in_div.side.x : 32'sd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_side_r <= in_div.side;
      s1_val_r  <= val_nxt;
      s1_prod_r <= ma * mb;
      s1_sat_r  <= in_div.cap || in_div.ovf;
      s1_dz_r   <= dz_nxt;
    end
  end

  // stage 2: derivative finish and clamp
  logic signed [49:0] sc;
  logic [31:0]        hi;
  logic [31:0]        res_nxt;
  logic               sat_nxt;

  always_comb begin
    sc      = s1_prod_r[65:16];
    hi      = s1_prod_r[47:16];
    res_nxt = s1_val_r;
    sat_nxt = 1'b0;
    case (s1_side_r.kind)
      KIND_LOGISTIC: begin
        if (s1_side_r.deriv == CMD_DERIV) res_nxt = hi;
      end
      KIND_TANH: begin
        if (s1_side_r.deriv == CMD_DERIV) res_nxt = ONE_FX - hi;
      end
      KIND_SOFTMAX: begin
        if (!s1_dz_r) begin
          sat_nxt = s1_sat_r;
          if (s1_side_r.deriv == CMD_DERIV) begin
            if (sc > 50'(MAX_VAL)) begin
              res_nxt = MAX_VAL;
              sat_nxt = 1'b1;
            end else if (sc < 50'(MIN_VAL)) begin
              res_nxt = MIN_VAL;
              sat_nxt = 1'b1;
            end else begin
              res_nxt = sc[31:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      out_value <= res_nxt;
      out_sat   <= sat_nxt;
      out_dz    <= s1_dz_r;
    end
  end

  assign out_valid = v2_r;

endmodule
`default_nettype wire

### rtl/core/neural_activation_unit_core.sv
// activation unit top level: config register, exp front end, divider chain, result stages
// pipeline: 7 exp stages, 31 divider cells and 2 result stages from input beat to result beat
// throughput: one beat per cycle unless out_tready stalls (31-cell restoring divider chain)
// each stage loads when empty or when the stage after it moves, so bubbles fill under stall
// reset: synchronous active-low rst_n clears all stage valids and act_kind to identity
`default_nettype none
module neural_activation_unit_core import nau_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // neuron_sum[31:0], exp_total[63:32]
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // act_value[31:0]
  output logic [1:0]       out_tuser,  // saturated[0], divide_by_zero[1]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [2:0] act_kind_r;
  logic       cfg_sel;

  assign cfg_sel    = (cfg_paddr[2] == CFG_IDX_ACT_KIND) && (cfg_paddr[1:0] == 2'b00);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_sel ? {29'b0, act_kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_kind_r <= KIND_IDENTITY;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == CFG_IDX_ACT_KIND)) begin
      act_kind_r <= cfg_pwdata[2:0];
    end
  end

  side_t in_side;

  assign in_side = '{kind: act_kind_r, deriv: in_tuser, x: $signed(in_tdata[31:0])};

  logic        cv_v  [0:QUO_W];
  div_t        cv_d  [0:QUO_W];
  logic        cl    [0:QUO_W];

  nau_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_side   (in_side),
    .in_total  (in_tdata[63:32]),
    .up_ld     (in_tready),
    .dn_ld     (cl[0]),
    .out_valid (cv_v[0]),
    .out_div   (cv_d[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    nau_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv_v[i]),
      .in_div    (cv_d[i]),
      .up_ld     (cl[i]),
      .dn_ld     (cl[i+1]),
      .out_valid (cv_v[i+1]),
      .out_div   (cv_d[i+1])
    );
  end

  nau_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_v[QUO_W]),
    .in_div    (cv_d[QUO_W]),
    .up_ld     (cl[QUO_W]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_value (out_tdata),
    .out_sat   (out_tuser[0]),
    .out_dz    (out_tuser[1])
  );

endmodule
`default_nettype wire

### rtl/core/nau_core_chk.sv
// port-level checker for the activation unit, bound to the top level
`default_nettype none
`include "neural_activation_unit_core_assert.svh"
module nau_core_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata
);

  `NAU_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `NAU_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  `NAU_ASSERT_IMP(a_dz_value, out_tvalid && out_tuser[1], out_tdata == 32'h7FFF_FFFF && !out_tuser[0])
  `NAU_ASSERT_IMP(a_no_false_stall, !out_tvalid || out_tready, in_tready)
  `NAU_ASSERT_NXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0, cfg_paddr != 3'd0 || cfg_prdata[2:0] == $past(cfg_pwdata[2:0]))

endmodule

bind neural_activation_unit_core nau_core_chk u_nau_core_chk (.*);
`default_nettype wire

### sim/neural_activation_unit_core_tb.sv
// self-checking testbench for the neural activation unit core
`timescale 1ns / 100ps
`default_nettype none
module neural_activation_unit_core_tb import nau_pkg::*; ();

  typedef struct {
    logic [31:0] value;
    logic        sat;
    logic        dz;
  } act_res_t;

  class act_scoreboard;
    logic [2:0]    kind;
    longint unsigned exp_rom [0:EXP_TABLE_DEPTH];
    act_res_t      pending_q[$];
    int            errors;

    function new();
      longint unsigned z, term, acc;
      kind = KIND_IDENTITY;
      errors = 0;
      for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
        z = longint'(i) * 64'd2977044472 / EXP_TABLE_DEPTH;
        term = 64'd1 << 32;
        acc = term;
        for (int k = 1; k <= 24; k++) begin
          term = ((term * z) >> 32) / k;
          acc = acc + term;
        end
        exp_rom[i] = (acc + 2) >> 2;
      end
    endfunction

    // e^x in fixed point via base-2 reduction and interpolated table
    function longint unsigned fx_exp(longint x, output bit capped);
      longint y, n, sh;
      longint unsigned frac, fd, idx, w, t0, t1, mant;
      capped = 0;
      y = (x * 64'sd1549082005) >>> 30;
      n = y >>> FRAC_BITS;
      frac = y & ((64'd1 << FRAC_BITS) - 1);
      fd = frac * EXP_TABLE_DEPTH;
      idx = fd >> FRAC_BITS;
      w = fd & ((64'd1 << FRAC_BITS) - 1);
      t0 = exp_rom[idx];
      t1 = exp_rom[idx + 1];
      mant = t0 + (((t1 - t0) * w) >> FRAC_BITS);
      sh = n + FRAC_BITS - 30;
      if (sh > 31) begin
        capped = 1;
        return 64'd1 << 62;
      end
      if (sh >= 0) return mant << sh;
      if (sh <= -63) return 0;
      return mant >> (-sh);
    endfunction

    function longint unsigned fx_logistic(longint x);
      bit c;
      longint unsigned e;
      e = fx_exp(-x, c);
      return (64'd1 << (2 * FRAC_BITS)) / ((64'd1 << FRAC_BITS) + e);
    endfunction

    function longint clamp32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
      return v;
    endfunction

    function void note_beat(logic cmd, logic signed [31:0] xs, logic [31:0] total);
      act_res_t r;
      longint x, res, t, f, onefx;
      longint unsigned lf, e, q, rm, tt;
      bit sat, dz, capped;
      bit deriv;
      deriv = (cmd == CMD_DERIV);
      x = xs;
      onefx = longint'(1) << FRAC_BITS;
      sat = 0;
      dz = 0;
      case (kind)
        KIND_IDENTITY: res = deriv ? onefx : x;
        KIND_LOGISTIC: begin
          lf = fx_logistic(x);
          res = deriv ? longint'((lf * (64'(onefx) - lf)) >> FRAC_BITS) : longint'(lf);
        end
        KIND_TANH: begin
          t = 2 * longint'(fx_logistic(2 * x)) - onefx;
          tt = longint'(t * t) >> FRAC_BITS;
          res = deriv ? onefx - longint'(tt) : t;
        end
        KIND_SOFTMAX: begin
          if (total == 0) begin
            dz = 1;
            res = 64'sd2147483647;
          end else begin
            e = fx_exp(x, capped);
            q = e / total;
            rm = e % total;
            if (capped) sat = 1;
            if (q >= (64'd1 << (31 - FRAC_BITS))) begin
              sat = 1;
              f = 64'sd2147483647;
            end else begin
              f = clamp32(longint'((q << FRAC_BITS) + ((rm << FRAC_BITS) / total)), sat);
            end
            res = deriv ? clamp32((f * (onefx - f)) >>> FRAC_BITS, sat) : f;
          end
        end
        default: begin
          if (deriv) res = x > 0 ? onefx : 0;
          else res = x > 0 ? x : 0;
        end
      endcase
      r.value = res[31:0];
      r.sat = sat;
      r.dz = dz;
      pending_q.push_back(r);
    endfunction

    function void check_beat(logic [31:0] value, logic [1:0] flags);
      act_res_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat value=%h flags=%b", $time, value, flags);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (value !== w.value) begin
        $display("%0t: act_value expected %h actual %h", $time, w.value, value);
        errors++;
      end
      if (flags[0] !== w.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, w.sat, flags[0]);
        errors++;
      end
      if (flags[1] !== w.dz) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time, w.dz, flags[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // neuron_sum[31:0], exp_total[63:32]
  logic        in_tuser = 0;    // cmd
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;       // act_value[31:0]
  logic [1:0]  out_tuser;       // saturated[0], divide_by_zero[1]
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  act_scoreboard act_sb = new();
  bit  calm = 0;
  int  quiet_cycles = 0;

  neural_activation_unit_core u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == 3'(CFG_IDX_ACT_KIND * 4))
        act_sb.kind = cfg_pwdata[2:0];
      if (in_tvalid && in_tready)
        act_sb.note_beat(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready)
        act_sb.check_beat(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 20000) begin
        $display("neural_activation_unit_core regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || $urandom_range(99) >= 26;
  end

  task automatic send_beat(logic cmd, logic [31:0] x, logic [31:0] total);
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {total, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (act_sb.pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_kind(logic [2:0] k);
    drain();
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= 3'(CFG_IDX_ACT_KIND * 4);
    cfg_pwdata <= {$urandom() & 32'hFFFF_FFF8, k};
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  function automatic logic [31:0] rand_sum();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * (48 << 16))) - (48 << 16));
      2: return 32'($signed($urandom_range(0, 2 * (4 << 16))) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic logic [31:0] rand_total();
    case ($urandom_range(9))
      0: return 0;
      1, 2: return $urandom();
      3: return $urandom_range(1, 255);
      default: return $urandom_range(1 << 12, 1 << 22);
    endcase
  endfunction

  logic [31:0] edge_sums [12] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
                                  32'h0001_0000, 32'hFFFF_0000, 32'h0020_0000, 32'h002E_0000,
                                  32'hFFD0_0000, 32'hFFB0_0000, 32'h0010_8000};
  logic [2:0] kind_plan [13] = '{KIND_LOGISTIC, KIND_TANH, KIND_RELU, KIND_SOFTMAX,
                                 KIND_IDENTITY, 3'd5, 3'd6, 3'd7, KIND_SOFTMAX, KIND_TANH,
                                 KIND_LOGISTIC, KIND_RELU, KIND_IDENTITY};

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    write_kind(KIND_SOFTMAX);
    for (int i = 0; i < 12; i++)
      send_beat(i[0], edge_sums[i], i % 4 == 0 ? 32'h0 : (i % 4 == 1 ? 32'hFFFF_FFFF :
                (i % 4 == 2 ? 32'h1 : 32'h0001_0000)));
    for (int i = 0; i < 12; i++)
      send_beat(!i[0], edge_sums[i], i % 3 == 0 ? 32'h1 : 32'h0001_0000);
    for (int p = 0; p < 13; p++) begin
      write_kind(kind_plan[p]);
      calm = (p == 4);
      for (int i = 0; i < 90; i++)
        send_beat($urandom_range(1), rand_sum(), rand_total());
      calm = 0;
    end
    drain();
    if (act_sb.errors == 0) begin
      $display("neural_activation_unit_core regression: pass");
    end else begin
      $display("neural_activation_unit_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
